FILE: rtl/core/glr_pkg.sv
package glr_pkg;

  localparam int COORD_W      = 6;
  localparam int LEN2_W       = 2 * COORD_W + 1;
  localparam int OFF_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 4;
  localparam int STOP_W       = 48;
  localparam int POS_W        = 16;
  localparam int COUNT_W      = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int QUEUE_DEPTH  = 2;
  localparam int Q_W          = 31;
  localparam int ROOT_W       = 32;
  localparam int NUM_W        = 24;
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = 30;
  localparam int SQRT_STEPS   = 16;
  localparam int BLEND_STEPS  = 8;

  localparam int REG_STOP_COUNT = 0;
  localparam int REG_STOP_FIRST = 1;
  localparam int NUM_STOP_REGS  = 4;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               sx_neg;
    logic               sy_neg;
    logic [LEN2_W-1:0]  len2;
    logic [POS_W-1:0]   region_x;
    logic [POS_W-1:0]   region_y;
  } line_desc_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIST,
    B_DIV,
    B_ROOT_LOAD,
    B_ROOT,
    B_ADV,
    B_PREP,
    B_MUL,
    B_BLEND,
    B_EMIT,
    B_STEP
  } back_state_t;

  function automatic logic [OFF_W-1:0] stop_off(input logic [STOP_W-1:0] s);
    stop_off = s[OFF_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] stop_chan(input logic [STOP_W-1:0] s,
                                                  input logic [1:0] c);
    case (c)
      2'd0:    stop_chan = s[47:40];
      2'd1:    stop_chan = s[39:32];
      2'd2:    stop_chan = s[31:24];
      default: stop_chan = s[23:16];
    endcase
  endfunction

endpackage

FILE: rtl/core/glr_front.sv
module glr_front import glr_pkg::*; #(
  parameter int TILE_BITS = 6,
  parameter int NW        = 3
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  start_x,
  input  logic [COORD_W-1:0]  start_y,
  input  logic [COORD_W-1:0]  end_x,
  input  logic [COORD_W-1:0]  end_y,
  input  logic [POS_W-1:0]    region_x,
  input  logic [POS_W-1:0]    region_y,
  input  logic [NW-1:0]       n_stops,
  input  logic                q_full,
  output logic                q_push,
  output line_desc_t          q_data
);

  localparam logic [COORD_W-1:0] TMASK = COORD_W'((1 << TILE_BITS) - 1);

  logic [COORD_W-1:0]   x0, y0, x1, y1, dx, dy;
  logic [2*COORD_W-1:0] dx2, dy2;
  logic                 drop;

  assign x0 = start_x & TMASK;
  assign y0 = start_y & TMASK;
  assign x1 = end_x & TMASK;
  assign y1 = end_y & TMASK;

  assign dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
  assign dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
  assign dx2 = {{COORD_W{1'b0}}, dx} * {{COORD_W{1'b0}}, dx};
  assign dy2 = {{COORD_W{1'b0}}, dy} * {{COORD_W{1'b0}}, dy};

  // Lines that draw nothing are taken and dropped here.
  assign drop = (n_stops < NW'(2)) || ((x0 == x1) && (y0 == y1));

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && !drop;

  always_comb begin
    q_data.x0       = x0;
    q_data.y0       = y0;
    q_data.x1       = x1;
    q_data.y1       = y1;
    q_data.dx       = dx;
    q_data.dy       = dy;
    q_data.sx_neg   = !(x0 < x1);
    q_data.sy_neg   = !(y0 < y1);
    q_data.len2     = {1'b0, dx2} + {1'b0, dy2};
    q_data.region_x = region_x;
    q_data.region_y = region_y;
  end

endmodule

FILE: rtl/core/glr_queue.sv
module glr_queue import glr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  line_desc_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output line_desc_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  line_desc_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/glr_back.sv
module glr_back import glr_pkg::*; #(
  parameter int MAX_STOPS = 4,
  parameter int NW        = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [NW-1:0]           n_stops,
  input  logic [STOP_W-1:0]       stops [MAX_STOPS],
  input  logic                    q_empty,
  output logic                    q_pop,
  input  line_desc_t              q_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] pixel_x,
  output logic signed [POS_W-1:0] pixel_y,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue,
  output logic [CHAN_W-1:0]       alpha_channel,
  output logic                    last
);

  localparam int IW = $clog2(MAX_STOPS);

  back_state_t state, state_next;
  line_desc_t  line;

  logic [COORD_W-1:0]      cx, cy, ax, ay;
  logic signed [8:0]       err;
  logic [LEN2_W-1:0]       d2, rem;
  logic [LEN2_W:0]         rem2;
  logic [Q_W-1:0]          q, sq_v, sq_bit;
  logic [ROOT_W-1:0]       sq_r, sq_sum;
  logic [STEP_W-1:0]       cnt;
  logic [OFF_W-1:0]        offset;
  logic                    started;
  logic [IW-1:0]           nxt;
  logic [STOP_W-1:0]       prev_stop, cur_stop;
  logic                    adv, at_end, out_load;
  logic signed [16:0]      dd;
  logic signed [17:0]      nn;
  logic [OFF_W-1:0]        dval, nval;
  logic [NUM_W-1:0]        num [NUM_CHAN];
  logic [NUM_W-1:0]        dsh;
  logic [CHAN_W-1:0]       quo [NUM_CHAN];
  logic signed [9:0]       e2, dx_s, dy_s, err_w;

  assign ax     = (cx >= line.x0) ? cx - line.x0 : line.x0 - cx;
  assign ay     = (cy >= line.y0) ? cy - line.y0 : line.y0 - cy;
  assign d2     = LEN2_W'({{COORD_W{1'b0}}, ax} * {{COORD_W{1'b0}}, ax})
                + LEN2_W'({{COORD_W{1'b0}}, ay} * {{COORD_W{1'b0}}, ay});
  assign rem2   = {rem, 1'b0};
  assign sq_sum = sq_r + {1'b0, sq_bit};
  assign offset = sq_r[OFF_W-1:0];
  assign cur_stop = stops[nxt];
  assign adv    = ((NW'(nxt) + NW'(1)) < n_stops) && (offset >= stop_off(cur_stop));
  assign at_end = (cx == line.x1) && (cy == line.y1);
  assign out_load = !out_valid || !out_stall;

  assign dd = signed'({1'b0, stop_off(cur_stop)}) - signed'({1'b0, stop_off(prev_stop)});
  assign nn = signed'({2'b0, offset}) - signed'({2'b0, stop_off(prev_stop)});

  assign e2   = {err, 1'b0};
  assign dx_s = signed'({4'b0, line.dx});
  assign dy_s = signed'({4'b0, line.dy});
  assign err_w = {err[8], err} - ((e2 > -dy_s) ? dy_s : 10'sd0)
               + ((e2 < dx_s) ? dx_s : 10'sd0);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (!q_empty) state_next = B_DIST;
      B_DIST:      state_next = (d2 >= line.len2) ? B_ROOT_LOAD : B_DIV;
      B_DIV:       if (cnt == STEP_W'(DIV_STEPS - 1)) state_next = B_ROOT_LOAD;
      B_ROOT_LOAD: state_next = B_ROOT;
      B_ROOT:      if (cnt == STEP_W'(SQRT_STEPS - 1)) state_next = B_ADV;
      B_ADV: begin
        if (!adv) state_next = started ? B_PREP : B_STEP;
      end
      B_PREP:      state_next = B_MUL;
      B_MUL:       state_next = B_BLEND;
      B_BLEND:     if (cnt == STEP_W'(BLEND_STEPS - 1)) state_next = B_EMIT;
      B_EMIT:      if (out_load) state_next = B_STEP;
      B_STEP:      state_next = at_end ? B_IDLE : B_DIST;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      nxt     <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          started <= 1'b0;
          nxt     <= '0;
        end
        B_ADV: begin
          if (adv) begin
            started <= 1'b1;
            nxt     <= nxt + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        line <= q_data;
        cx   <= q_data.x0;
        cy   <= q_data.y0;
        err  <= 9'(signed'({3'b0, q_data.dx}) - signed'({3'b0, q_data.dy}));
      end
      B_DIST: begin
        rem <= d2;
        cnt <= '0;
        q   <= (d2 >= line.len2) ? Q_W'(1 << 30) : '0;
      end
      B_DIV: begin
        if (rem2 >= {1'b0, line.len2}) begin
          rem <= LEN2_W'(rem2 - {1'b0, line.len2});
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          rem <= rem2[LEN2_W-1:0];
          q   <= {q[Q_W-2:0], 1'b0};
        end
        cnt <= cnt + STEP_W'(1);
      end
      B_ROOT_LOAD: begin
        sq_v   <= q;
        sq_r   <= '0;
        sq_bit <= Q_W'(1 << 30);
        cnt    <= '0;
      end
      B_ROOT: begin
        if ({1'b0, sq_v} >= sq_sum) begin
          sq_v <= Q_W'({1'b0, sq_v} - sq_sum);
          sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + STEP_W'(1);
      end
      B_ADV: begin
        if (adv) prev_stop <= cur_stop;
      end
      B_PREP: begin
        if (dd <= 17'sd0) begin
          dval <= OFF_W'(1);
          nval <= OFF_W'(1);
        end else begin
          dval <= dd[OFF_W-1:0];
          if (nn < 18'sd0) begin
            nval <= '0;
          end else if (nn > 18'(dd)) begin
            nval <= dd[OFF_W-1:0];
          end else begin
            nval <= nn[OFF_W-1:0];
          end
        end
      end
      B_MUL: begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          num[c] <= NUM_W'(dval - nval) * NUM_W'(stop_chan(prev_stop, 2'(c)))
                  + NUM_W'(nval) * NUM_W'(stop_chan(cur_stop, 2'(c)));
          quo[c] <= '0;
        end
        dsh <= {1'b0, dval, 7'b0};
        cnt <= '0;
      end
      B_BLEND: begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (num[c] >= dsh) begin
            num[c] <= num[c] - dsh;
            quo[c] <= {quo[c][CHAN_W-2:0], 1'b1};
          end else begin
            quo[c] <= {quo[c][CHAN_W-2:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
        cnt <= cnt + STEP_W'(1);
      end
      B_STEP: begin
        if (!at_end) begin
          err <= err_w[8:0];
          if (e2 > -dy_s) cx <= line.sx_neg ? cx - COORD_W'(1) : cx + COORD_W'(1);
          if (e2 < dx_s)  cy <= line.sy_neg ? cy - COORD_W'(1) : cy + COORD_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_EMIT) && out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_EMIT) && out_load) begin
      pixel_x       <= line.region_x + {{(POS_W - COORD_W){1'b0}}, cx};
      pixel_y       <= line.region_y + {{(POS_W - COORD_W){1'b0}}, cy};
      red           <= quo[0];
      green         <= quo[1];
      blue          <= quo[2];
      alpha_channel <= quo[3];
      last          <= at_end;
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && out_valid && out_stall) |=> (state == B_EMIT))
    else $error("pixel emitted while output word still held");

  a_started_index: assert property (@(posedge clk) disable iff (rst)
    started |-> (nxt != '0))
    else $error("blend started without a lower stop");

  a_step_source: assert property (@(posedge clk) disable iff (rst)
    (state == B_STEP) |-> ($past(state) == B_EMIT || $past(state) == B_ADV))
    else $error("walk advanced without finishing the pixel");

endmodule

FILE: rtl/core/gradient_line_rasterizer.sv
// The front takes each line word in its accept cycle; drawn lines wait in a two-word queue.
// A drawn pixel passes in the back through a division of distance over length, a square
// root, a color division and the single states DIST, ROOT_LOAD, ADV, PREP, MUL, EMIT and
// STEP, plus a pass through ADV per stop crossed. The end pixel skips the division, and
// a pixel before the first stop skips the color division and is not emitted.
// Synchronous reset clears the control state and stop registers and empties the queue.
module gradient_line_rasterizer import glr_pkg::*; #(
  parameter int MAX_STOPS = 4,
  parameter int TILE_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_W-1:0]      start_x,
  input  logic [COORD_W-1:0]      start_y,
  input  logic [COORD_W-1:0]      end_x,
  input  logic [COORD_W-1:0]      end_y,
  input  logic signed [POS_W-1:0] region_x,
  input  logic signed [POS_W-1:0] region_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] pixel_x,
  output logic signed [POS_W-1:0] pixel_y,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue,
  output logic [CHAN_W-1:0]       alpha_channel,
  output logic                    last
);

  localparam int NW = $clog2(MAX_STOPS + 1);

  logic [COUNT_W-1:0] stop_count;
  logic [STOP_W-1:0]  stops [MAX_STOPS];
  logic [NW-1:0]      n_stops;
  logic               q_full, q_push, q_empty, q_pop;
  line_desc_t         q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
    end else if (cfg_write_en && cfg_index == CFG_INDEX_W'(REG_STOP_COUNT)) begin
      stop_count <= cfg_data[COUNT_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_stop
    if (i < NUM_STOP_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          stops[i] <= '0;
        end else if (cfg_write_en && cfg_index == CFG_INDEX_W'(REG_STOP_FIRST + i)) begin
          stops[i] <= cfg_data[STOP_W-1:0];
        end
      end
    end else begin : g_zero
      assign stops[i] = '0;
    end
  end

  assign n_stops = (32'(stop_count) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(stop_count);

  glr_front #(
    .TILE_BITS (TILE_BITS),
    .NW        (NW)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .region_x (region_x),
    .region_y (region_y),
    .n_stops  (n_stops),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  glr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  glr_back #(
    .MAX_STOPS (MAX_STOPS),
    .NW        (NW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .n_stops       (n_stops),
    .stops         (stops),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha_channel (alpha_channel),
    .last          (last)
  );

endmodule

FILE: dv/glr_pixel_checker.sv
`timescale 1ns / 100ps

module glr_pixel_checker import glr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [COORD_W-1:0]     start_x,
  input  logic [COORD_W-1:0]     start_y,
  input  logic [COORD_W-1:0]     end_x,
  input  logic [COORD_W-1:0]     end_y,
  input  logic [POS_W-1:0]       region_x,
  input  logic [POS_W-1:0]       region_y,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [POS_W-1:0]       pixel_x,
  input  logic [POS_W-1:0]       pixel_y,
  input  logic [CHAN_W-1:0]      red,
  input  logic [CHAN_W-1:0]      green,
  input  logic [CHAN_W-1:0]      blue,
  input  logic [CHAN_W-1:0]      alpha_channel,
  input  logic                   last,
  output int                     fail_count,
  output int                     pending_pixels,
  output int                     checked_pixels
);

  localparam int STOPS = 4;

  typedef struct {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [CHAN_W-1:0] chan [NUM_CHAN];
    logic              fin;
  } pixel_t;

  logic [COUNT_W-1:0] active_stops;
  logic [STOP_W-1:0]  stop_word [STOPS];
  pixel_t             expected_pixels [$];

  initial begin
    fail_count = 0;
    pending_pixels = 0;
    checked_pixels = 0;
  end

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int offset_of(input int i);
    return int'(stop_word[i][OFF_W-1:0]);
  endfunction

  // Walks one line and queues the colored pixels it should produce.
  function automatic void predict_line(input int x0, input int y0, input int x1, input int y1,
                                       input logic [POS_W-1:0] rx, input logic [POS_W-1:0] ry);
    int n, xs, ys, dx, dy, sx, sy, err, e2, lo, hi, guard, ax, ay, off, dd, nn, c, sh;
    longint unsigned len2, d2, q, v, cp, cn;
    pixel_t p;
    pixel_t line_pixels [$];
    n = (active_stops > STOPS) ? STOPS : int'(active_stops);
    if (n < 2 || (x0 == x1 && y0 == y1)) return;
    xs = x0;
    ys = y0;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    len2 = longint'(dx * dx + dy * dy);
    lo = -1;
    hi = 0;
    for (guard = 0; guard < 64; guard++) begin
      ax = x0 - xs;
      ay = y0 - ys;
      d2 = longint'(ax * ax + ay * ay);
      q = (d2 << 30) / len2;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      off = int'(root_floor(q));
      while (hi + 1 < n && off >= offset_of(hi)) begin
        lo++;
        hi++;
      end
      if (lo >= 0) begin
        dd = offset_of(hi) - offset_of(lo);
        nn = off - offset_of(lo);
        if (dd <= 0) begin
          dd = 1;
          nn = 1;
        end
        if (nn < 0) nn = 0;
        if (nn > dd) nn = dd;
        p.px = rx + POS_W'(x0);
        p.py = ry + POS_W'(y0);
        for (c = 0; c < NUM_CHAN; c++) begin
          sh = 40 - 8 * c;
          cp = (stop_word[lo] >> sh) & 64'hFF;
          cn = (stop_word[hi] >> sh) & 64'hFF;
          v = (longint'(dd - nn) * cp + longint'(nn) * cn) / longint'(dd);
          p.chan[c] = v[CHAN_W-1:0];
        end
        p.fin = 1'b0;
        line_pixels = {line_pixels, p};
      end
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err = err - dy;
        x0 = x0 + sx;
      end
      if (e2 < dx) begin
        err = err + dx;
        y0 = y0 + sy;
      end
    end
    if (line_pixels.size() > 0) line_pixels[line_pixels.size() - 1].fin = 1'b1;
    expected_pixels = {expected_pixels, line_pixels};
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      active_stops = '0;
      foreach (stop_word[i]) stop_word[i] = '0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_STOP_COUNT) begin
          active_stops = cfg_data[COUNT_W-1:0];
        end else if (cfg_index >= REG_STOP_FIRST &&
                     cfg_index < REG_STOP_FIRST + NUM_STOP_REGS) begin
          stop_word[cfg_index - REG_STOP_FIRST] = cfg_data;
        end
      end
      if (in_valid && !in_stall)
        predict_line(start_x, start_y, end_x, end_y, region_x, region_y);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("Unexpected pixel at x %0d y %0d", pixel_x, pixel_y);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("pixel_x", e.px, pixel_x);
          check_field("pixel_y", e.py, pixel_y);
          check_field("red", e.chan[0], red);
          check_field("green", e.chan[1], green);
          check_field("blue", e.chan[2], blue);
          check_field("alpha_channel", e.chan[3], alpha_channel);
          check_field("last", e.fin, last);
          checked_pixels++;
        end
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

FILE: dv/gradient_line_rasterizer_test.sv
`timescale 1ns / 100ps

module gradient_line_rasterizer_test;
  import glr_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int DRAIN_CYCLES = 13000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [COORD_W-1:0]     start_x, start_y, end_x, end_y;
  logic signed [POS_W-1:0] region_x, region_y;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [POS_W-1:0] pixel_x, pixel_y;
  logic [CHAN_W-1:0]      red, green, blue, alpha_channel;
  logic                   last;
  int                     fail_count, pending_pixels, checked_pixels;
  int                     cycles = 0;
  int                     lines_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gradient_line_rasterizer u_top (.*);

  glr_pixel_checker u_checker (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .start_x, .start_y, .end_x, .end_y, .region_x, .region_y,
    .out_valid, .out_stall, .pixel_x, .pixel_y, .red, .green, .blue,
    .alpha_channel, .last, .fail_count, .pending_pixels, .checked_pixels
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int len;
    logic s;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        s = 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 4);
      end else begin
        s = 1'b0;
        len = $urandom_range(1, 20);
      end
      repeat (len) begin
        @(negedge clk);
        out_stall <= s;
      end
    end
  end

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data <= value;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [STOP_W-1:0] color_stop(input int off);
    return {$urandom(), off[OFF_W-1:0]};
  endfunction

  task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [POS_W-1:0] rx, input logic [POS_W-1:0] ry);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) :
          ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_x <= COORD_W'(sx);
    start_y <= COORD_W'(sy);
    end_x <= COORD_W'(ex);
    end_y <= COORD_W'(ey);
    region_x <= rx;
    region_y <= ry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines_sent++;
    @(negedge clk);
  endtask

  function automatic int near_end(input int s);
    int d;
    d = int'($urandom_range(0, 16)) - 8;
    if (s + d < 0 || s + d > 63) d = -d;
    return s + d;
  endfunction

  function automatic logic [POS_W-1:0] pick_region();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h7FE0;
      3: return 16'hFFF0;
      default: return POS_W'($urandom());
    endcase
  endfunction

  task automatic random_lines(input int count);
    int sx, sy, ex, ey, mode;
    repeat (count) begin
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        ex = sx;
        ey = sy;
      end else if (mode < 4) begin
        ex = $urandom_range(0, 63);
        ey = $urandom_range(0, 63);
      end else begin
        ex = near_end(sx);
        ey = near_end(sy);
      end
      send_line(sx, sy, ex, ey, pick_region(), pick_region());
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_pixels != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int off, i;
    logic unsorted;
    unsorted = ($urandom_range(0, 3) == 0);
    off = 0;
    write_reg(REG_STOP_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
    for (i = 0; i < NUM_STOP_REGS; i++) begin
      if (unsorted) off = $urandom_range(0, 65535);
      else off = off + $urandom_range(0, 12000);
      write_reg(REG_STOP_FIRST + i, color_stop(off));
    end
    write_reg($urandom_range(REG_STOP_FIRST + NUM_STOP_REGS, 7), {$urandom(), 16'hFFFF});
    end_writes();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    region_x = '0;
    region_y = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    random_lines(8);
    settle();

    write_reg(REG_STOP_COUNT, CFG_DATA_W'(4));
    write_reg(REG_STOP_FIRST, {32'h00FF00FF, 16'h0000});
    write_reg(REG_STOP_FIRST + 1, {32'hFF00FF00, 16'h2000});
    write_reg(REG_STOP_FIRST + 2, {32'h12345678, 16'h6000});
    write_reg(REG_STOP_FIRST + 3, {32'hFFFFFFFF, 16'h8000});
    end_writes();
    send_line(0, 0, 63, 63, 16'h0000, 16'h0000);
    send_line(63, 63, 0, 0, 16'h7FFF, 16'h8000);
    send_line(0, 63, 63, 0, 16'h8000, 16'h7FFF);
    send_line(63, 0, 0, 63, 16'hFFFF, 16'hFFC1);
    send_line(0, 10, 63, 10, 16'h7FE0, 16'h0000);
    send_line(20, 0, 20, 63, 16'h0000, 16'h7FE0);
    send_line(5, 5, 5, 5, 16'h1234, 16'h4321);
    send_line(3, 0, 9, 40, 16'h0010, 16'h0020);
    send_line(40, 7, 1, 11, 16'hFFF0, 16'hFFF0);
    send_line(31, 31, 32, 32, 16'h0000, 16'h0000);
    send_line(31, 31, 32, 31, 16'h7FFF, 16'h7FFF);
    send_line(0, 0, 1, 63, 16'h8000, 16'h8000);
    random_lines(55);
    settle();

    write_reg(REG_STOP_COUNT, CFG_DATA_W'(2));
    write_reg(REG_STOP_FIRST, color_stop(16'h4000));
    write_reg(REG_STOP_FIRST + 1, color_stop(16'hFFFF));
    end_writes();
    random_lines(60);
    settle();

    write_reg(REG_STOP_COUNT, CFG_DATA_W'(3));
    write_reg(REG_STOP_FIRST, color_stop(16'h6000));
    write_reg(REG_STOP_FIRST + 1, color_stop(16'h1000));
    write_reg(REG_STOP_FIRST + 2, color_stop(16'h3000));
    end_writes();
    random_lines(60);
    settle();

    write_reg(REG_STOP_COUNT, CFG_DATA_W'(7));
    write_reg(REG_STOP_FIRST, color_stop(16'h0000));
    write_reg(REG_STOP_FIRST + 1, color_stop(16'h4000));
    write_reg(REG_STOP_FIRST + 2, color_stop(16'h4000));
    write_reg(REG_STOP_FIRST + 3, color_stop(16'h4000));
    write_reg(REG_STOP_FIRST + NUM_STOP_REGS, '1);
    end_writes();
    random_lines(60);
    settle();

    write_reg(REG_STOP_COUNT, CFG_DATA_W'(1));
    end_writes();
    random_lines(8);
    settle();

    repeat (4) begin
      random_config();
      random_lines(37);
      settle();
    end

    $display("Sent %0d lines over several stop settings, checked %0d pixels.",
             lines_sent, checked_pixels);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
